### design/bsh256_pkg.sv
// Constants and helpers shared by the byte stream hash design.
package bsh256_pkg;

   localparam int unsigned LaneWidth = 64;
   localparam int unsigned HalfWidth = LaneWidth / 2;

   typedef logic [LaneWidth-1:0] lane_type;
   typedef logic [HalfWidth-1:0] half_type;

   localparam lane_type INIT_A = 64'h428a2f98d728ae22;
   localparam lane_type INIT_B = 64'h7137449123ef65cd;
   localparam lane_type INIT_C = 64'hb5c0fbcfec4d3b2f;
   localparam lane_type INIT_D = 64'he9b5dba58189dbbc;

   localparam lane_type PRIME1 = 64'h9e3779b185ebca87;
   localparam lane_type PRIME2 = 64'hc2b2ae3d27d4eb4f;
   localparam lane_type PRIME3 = 64'h165667b19e3779f9;
   localparam lane_type PRIME4 = 64'h85ebca77c2b2ae63;

   // Right rotations are written as the matching left rotation.
   localparam int unsigned ROT_ONE   = 13;
   localparam int unsigned ROT_TWO   = LaneWidth - 17;
   localparam int unsigned ROT_THREE = 31;
   localparam int unsigned ROT_FOUR  = LaneWidth - 19;
   localparam int unsigned ROT_MIX_A = 23;
   localparam int unsigned ROT_MIX_B = 41;

   function automatic lane_type rol(input lane_type v, input int unsigned s);
      lane_type r;
      r = (v << s) | (v >> (LaneWidth - s));
      return r;
   endfunction

endpackage

### design/byte_stream_hash_256.sv
// Byte stream hash, 256-bit digest: top level with shared multiplier and sequencer.
//
// Input channel req_: one transfer per message byte (req_tuser = 0, byte in
// req_tdata) or a finalize command (req_tuser = 1, req_tdata ignored).
// Result channel rsp_: one transfer per finalize, carrying the four 64-bit
// digest words; bytes produce no result.
// All 64-bit products come from one 32x32 multiplier; a 64-bit product (low
// half) is built from three partial products and a final add.
// A byte keeps the sequencer busy for six products after its transfer; every
// fourth byte adds the lane cross-mix, four more products. A finalize runs four
// length products, four mix products and four add steps before its digest is
// loaded into the output register. The sequencer then returns to idle, so a
// new byte is taken only once the last one is through.
// req_tready is high only while the sequencer is idle. The digest waits in the
// output register until taken; further bytes are accepted meanwhile, but a
// following finalize holds in its last step until the output register frees.
// After reset the lanes hold their initial constants, the byte count is zero,
// no result is pending and the block is ready at once.
module byte_stream_hash_256 (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] command (0 absorb, 1 finalize)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata    // [63:0] digest_word0, [127:64] digest_word1,
                                     // [191:128] digest_word2, [255:192] digest_word3
);
   import bsh256_pkg::*;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_POS   = 5'd1;
   localparam logic [4:0] ST_BYTE1 = 5'd2;
   localparam logic [4:0] ST_LANE1 = 5'd3;
   localparam logic [4:0] ST_BYTE2 = 5'd4;
   localparam logic [4:0] ST_BYTE3 = 5'd5;
   localparam logic [4:0] ST_BYTE4 = 5'd6;
   localparam logic [4:0] ST_MIX1  = 5'd7;
   localparam logic [4:0] ST_MIX2  = 5'd8;
   localparam logic [4:0] ST_MIX3  = 5'd9;
   localparam logic [4:0] ST_MIX4  = 5'd10;
   localparam logic [4:0] ST_FIN1  = 5'd11;
   localparam logic [4:0] ST_FIN2  = 5'd12;
   localparam logic [4:0] ST_FIN3  = 5'd13;
   localparam logic [4:0] ST_FIN4  = 5'd14;
   localparam logic [4:0] ST_SUM1  = 5'd15;
   localparam logic [4:0] ST_SUM2  = 5'd16;
   localparam logic [4:0] ST_SUM3  = 5'd17;
   localparam logic [4:0] ST_SUM4  = 5'd18;

   localparam logic [1:0] PH_LAST = 2'd3;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   lane_type    lane1_ff, lane1_in;
   lane_type    lane2_ff, lane2_in;
   lane_type    lane3_ff, lane3_in;
   lane_type    lane4_ff, lane4_in;
   lane_type    count_ff, count_in;
   lane_type    mixed_ff, mixed_in;     // byte xor position product
   logic [7:0]  byte_ff, byte_in;
   logic        final_ff, final_in;
   lane_type    prod_ff, prod_in;
   lane_type    acc_ff, acc_in;
   logic        out_valid_ff, out_valid_in;
   logic [255:0] out_data_ff, out_data_in;

   lane_type    op_a, op_k, result, pos;
   half_type    mul_x, mul_y;
   logic        is_mul, is_sum, out_free;

   assign pos      = count_ff + 64'd1;
   assign out_free = !out_valid_ff || rsp_tready;
   assign is_sum   = (state_ff == ST_SUM1) || (state_ff == ST_SUM2) ||
                     (state_ff == ST_SUM3) || (state_ff == ST_SUM4);
   assign is_mul   = (state_ff != ST_IDLE) && !is_sum;

   // Operand and constant for the product of the current step.
   always_comb begin
      op_a = count_ff;
      op_k = PRIME1;
      unique case (state_ff)
         ST_POS:   begin op_a = pos;      op_k = PRIME1; end
         ST_BYTE1: begin op_a = mixed_ff; op_k = PRIME1; end
         ST_LANE1: begin op_a = lane1_ff; op_k = PRIME2; end
         ST_BYTE2: begin op_a = mixed_ff; op_k = PRIME2; end
         ST_BYTE3: begin op_a = mixed_ff; op_k = PRIME3; end
         ST_BYTE4: begin op_a = mixed_ff; op_k = PRIME4; end
         ST_MIX1:  begin op_a = rol(lane1_ff ^ lane2_ff, ROT_MIX_A); op_k = PRIME1; end
         ST_MIX2:  begin op_a = rol(lane2_ff ^ lane3_ff, ROT_MIX_A); op_k = PRIME1; end
         ST_MIX3:  begin op_a = rol(lane3_ff ^ lane4_ff, ROT_MIX_A); op_k = PRIME1; end
         ST_MIX4:  begin op_a = rol(lane4_ff ^ lane1_ff, ROT_MIX_A); op_k = PRIME1; end
         ST_FIN1:  begin op_a = count_ff; op_k = PRIME1; end
         ST_FIN2:  begin op_a = count_ff; op_k = PRIME2; end
         ST_FIN3:  begin op_a = count_ff; op_k = PRIME3; end
         ST_FIN4:  begin op_a = count_ff; op_k = PRIME4; end
         default:  begin op_a = count_ff; op_k = PRIME1; end
      endcase
   end

   // Low 64 bits of op_a * op_k: lo*lo, then hi*lo and lo*hi shifted up.
   always_comb begin
      unique case (phase_ff)
         2'd1:    begin mul_x = op_a[LaneWidth-1:HalfWidth]; mul_y = op_k[HalfWidth-1:0]; end
         2'd2:    begin mul_x = op_a[HalfWidth-1:0]; mul_y = op_k[LaneWidth-1:HalfWidth]; end
         default: begin mul_x = op_a[HalfWidth-1:0]; mul_y = op_k[HalfWidth-1:0]; end
      endcase
   end

   assign prod_in = LaneWidth'(mul_x) * LaneWidth'(mul_y);
   assign result  = acc_ff + {prod_ff[HalfWidth-1:0], {HalfWidth{1'b0}}};

   always_comb begin
      acc_in = acc_ff;
      if (phase_ff == 2'd1) begin
         acc_in = prod_ff;
      end else if (phase_ff == 2'd2) begin
         acc_in = result;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      lane1_in     = lane1_ff;
      lane2_in     = lane2_ff;
      lane3_in     = lane3_ff;
      lane4_in     = lane4_ff;
      count_in     = count_ff;
      mixed_in     = mixed_ff;
      byte_in      = byte_ff;
      final_in     = final_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;

      if (is_mul) begin
         phase_in = phase_ff + 2'd1;
      end

      if (state_ff == ST_IDLE) begin
         if (req_tvalid) begin
            byte_in  = req_tdata;
            final_in = req_tuser;
            state_in = req_tuser ? ST_FIN1 : ST_POS;
         end
      end else if (is_sum) begin
         unique case (state_ff)
            ST_SUM1: begin lane1_in = lane1_ff + lane2_ff; state_in = ST_SUM2; end
            ST_SUM2: begin lane1_in = lane1_ff + lane3_ff; state_in = ST_SUM3; end
            ST_SUM3: begin lane1_in = lane1_ff + lane4_ff; state_in = ST_SUM4; end
            default: begin
               // Hold until the output register can take the digest.
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_data_in  = {lane4_ff + lane1_ff, lane3_ff + lane1_ff,
                                  lane2_ff + lane1_ff, lane1_ff};
                  lane1_in     = INIT_A;
                  lane2_in     = INIT_B;
                  lane3_in     = INIT_C;
                  lane4_in     = INIT_D;
                  count_in     = '0;
                  state_in     = ST_IDLE;
               end
            end
         endcase
      end else if (phase_ff == PH_LAST) begin
         unique case (state_ff)
            ST_POS: begin
               mixed_in = {{(LaneWidth-8){1'b0}}, byte_ff} ^ result;
               state_in = ST_BYTE1;
            end
            ST_BYTE1: begin
               lane1_in = rol(lane1_ff ^ result, ROT_ONE);
               state_in = ST_LANE1;
            end
            ST_LANE1: begin
               lane1_in = result;
               state_in = ST_BYTE2;
            end
            ST_BYTE2: begin
               lane2_in = rol(lane2_ff ^ result, ROT_TWO) + lane1_ff;
               state_in = ST_BYTE3;
            end
            ST_BYTE3: begin
               lane3_in = rol(lane3_ff ^ result, ROT_THREE) ^ lane2_ff;
               state_in = ST_BYTE4;
            end
            ST_BYTE4: begin
               lane4_in = rol(lane4_ff ^ result, ROT_FOUR) + lane3_ff;
               count_in = pos;
               state_in = (count_ff[1:0] == 2'd3) ? ST_MIX1 : ST_IDLE;
            end
            ST_MIX1: begin
               lane1_in = rol(result ^ lane3_ff, ROT_MIX_B);
               state_in = ST_MIX2;
            end
            ST_MIX2: begin
               lane2_in = rol(result ^ lane4_ff, ROT_MIX_B);
               state_in = ST_MIX3;
            end
            ST_MIX3: begin
               lane3_in = rol(result ^ lane1_ff, ROT_MIX_B);
               state_in = ST_MIX4;
            end
            ST_MIX4: begin
               lane4_in = rol(result ^ lane2_ff, ROT_MIX_B);
               state_in = final_ff ? ST_SUM1 : ST_IDLE;
            end
            ST_FIN1: begin lane1_in = lane1_ff ^ result; state_in = ST_FIN2; end
            ST_FIN2: begin lane2_in = lane2_ff ^ result; state_in = ST_FIN3; end
            ST_FIN3: begin lane3_in = lane3_ff ^ result; state_in = ST_FIN4; end
            default: begin lane4_in = lane4_ff ^ result; state_in = ST_MIX1; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         lane1_ff     <= INIT_A;
         lane2_ff     <= INIT_B;
         lane3_ff     <= INIT_C;
         lane4_ff     <= INIT_D;
         count_ff     <= '0;
         final_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         lane1_ff     <= lane1_in;
         lane2_ff     <= lane2_in;
         lane3_ff     <= lane3_in;
         lane4_ff     <= lane4_in;
         count_ff     <= count_in;
         final_ff     <= final_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mixed_ff    <= mixed_in;
      byte_ff     <= byte_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      out_data_ff <= out_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // The multiply phase only runs inside product steps.
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      !is_mul |-> phase_ff == 2'd0)
      else $error("multiply phase active outside a product step");

   // Emitting a digest returns the lanes and count to their initial values.
   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM4 && out_free) |=>
         (count_ff == '0 && lane1_ff == INIT_A && rsp_tvalid && state_ff == ST_IDLE))
      else $error("digest emitted without state return");

   // The byte count moves only at the end of a byte or on a digest.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == ST_BYTE4 || $past(state_ff) == ST_SUM4))
      else $error("byte count changed outside its update steps");

endmodule

### sim/tb.sv
// Self-checking testbench for the byte stream hash with a 256-bit digest.
`timescale 1ns / 100ps

module tb;
   import bsh256_pkg::*;

   localparam int unsigned StallLimit = 4000;
   localparam int unsigned TailCycles = 64;
   localparam int unsigned RandomItems = 800;

   typedef struct {
      lane_type w0;
      lane_type w1;
      lane_type w2;
      lane_type w3;
   } digest_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;   // [7:0] data_byte
   logic         req_tuser = 1'b0;   // [0] command (0 absorb, 1 finalize)
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;          // [63:0] word0, [127:64] word1,
                                     // [191:128] word2, [255:192] word3

   // Predicted hash state
   lane_type h1 = INIT_A;
   lane_type h2 = INIT_B;
   lane_type h3 = INIT_C;
   lane_type h4 = INIT_D;
   lane_type msg_len = '0;

   digest_type  pending_digests[$];
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;

   int unsigned stall_mode = 0;
   int unsigned stall_timer = 0;
   logic [7:0]  stall_mask = 8'hff;
   logic [2:0]  stall_phase = 3'd0;

   byte_stream_hash_256 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic lane_type rotl(input lane_type v, input int unsigned s);
      int unsigned n;
      n = s % 64;
      if (n == 0) return v;
      return (v << n) | (v >> (64 - n));
   endfunction

   function automatic lane_type blend(input lane_type x, input lane_type y,
                                      input lane_type z);
      lane_type t;
      t = rotl(x ^ y, 23) * PRIME1;
      return rotl(t ^ z, 41);
   endfunction

   task automatic stir_lanes;
      h1 = blend(h1, h2, h3);
      h2 = blend(h2, h3, h4);
      h3 = blend(h3, h4, h1);
      h4 = blend(h4, h1, h2);
   endtask

   task automatic absorb_byte(input logic [7:0] value);
      lane_type pos;
      lane_type b;
      pos = msg_len + 1;
      b = {56'd0, value} ^ (pos * PRIME1);
      h1 = rotl(h1 ^ (b * PRIME1), 13) * PRIME2;
      h2 = rotl(h2 ^ (b * PRIME2), 64 - 17) + h1;
      h3 = rotl(h3 ^ (b * PRIME3), 31) ^ h2;
      h4 = rotl(h4 ^ (b * PRIME4), 64 - 19) + h3;
      if (msg_len[1:0] == 2'b11) stir_lanes();
      msg_len = pos;
   endtask

   task automatic finalize_digest(output digest_type d);
      h1 ^= msg_len * PRIME1;
      h2 ^= msg_len * PRIME2;
      h3 ^= msg_len * PRIME3;
      h4 ^= msg_len * PRIME4;
      stir_lanes();
      h1 = h1 + h2 + h3 + h4;
      h2 += h1;
      h3 += h1;
      h4 += h1;
      d.w0 = h1;
      d.w1 = h2;
      d.w2 = h3;
      d.w3 = h4;
      h1 = INIT_A;
      h2 = INIT_B;
      h3 = INIT_C;
      h4 = INIT_D;
      msg_len = '0;
   endtask

   // Drive one item, wait for its transfer, then predict. Valid stays high so
   // that back-to-back calls in the same step keep the stream going.
   task automatic send_item(input logic fin, input logic [7:0] value);
      digest_type d;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fin;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
      if (fin) begin
         finalize_digest(d);
         pending_digests.push_back(d);
      end else begin
         absorb_byte(value);
      end
   endtask

   // Drop valid, then wait on the clock before anything is driven again.
   task automatic stop_sending;
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_message(input int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
      send_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // Hold the sender until every digest has come out.
   task automatic drain_digests;
      stop_sending();
      while (pending_digests.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input lane_type got,
                                  input lane_type want);
      $display("tb: %s mismatch got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Empty message right after reset and right after another digest; data on
   // the finalize must have no effect.
   task automatic test_empty_message;
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'hff);
      stop_sending();
   endtask

   task automatic test_byte_extremes;
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hff);
      send_item(1'b1, 8'h5a);
      send_item(1'b0, 8'hff);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'haa);
      send_item(1'b0, 8'h55);
      send_item(1'b1, 8'h00);
      stop_sending();
   endtask

   // Lengths just past and exactly on the four-byte mixing boundary.
   task automatic test_mix_boundary;
      send_message(5);
      send_message(8);
      stop_sending();
   endtask

   task automatic test_drain_pause;
      send_message(3);
      drain_digests();
      send_item(1'b1, 8'h01);
      send_message(1);
      drain_digests();
   endtask

   task automatic test_random_messages;
      int unsigned len;
      int unsigned i;
      int unsigned pick;
      logic [7:0]  value;
      while (items_sent < RandomItems + 25) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            drain_digests();
         end else if (pick == 1) begin
            // noise: a stray command with random data
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(0, 16);
            for (i = 0; i < len; i++) begin
               case ($urandom_range(0, 7))
                  0: value = 8'h00;
                  1: value = 8'hff;
                  default: value = 8'($urandom_range(0, 255));
               endcase
               send_item(1'b0, value);
            end
            send_item(1'b1, 8'($urandom_range(0, 255)));
         end
      end
      stop_sending();
   endtask

   // Receiver stall pattern: always ready, a rotating mask, or coin tosses.
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_mask  <= 8'($urandom_range(0, 255)) | 8'h01;
         stall_timer <= $urandom_range(20, 80);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      stall_phase <= stall_phase + 3'd1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= stall_mask[stall_phase];
         default: rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digests.size() == 0) begin
            $display("tb: unexpected digest %h at %0t", rsp_tdata, $realtime);
            error_count++;
         end else begin
            want = pending_digests.pop_front();
            if (rsp_tdata[63:0] !== want.w0)
               report_mismatch("digest_word0", rsp_tdata[63:0], want.w0);
            if (rsp_tdata[127:64] !== want.w1)
               report_mismatch("digest_word1", rsp_tdata[127:64], want.w1);
            if (rsp_tdata[191:128] !== want.w2)
               report_mismatch("digest_word2", rsp_tdata[191:128], want.w2);
            if (rsp_tdata[255:192] !== want.w3)
               report_mismatch("digest_word3", rsp_tdata[255:192], want.w3);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_byte_extremes();
      test_mix_boundary();
      test_drain_pause();
      test_random_messages();
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
